[hw/rtl/binary_to_decimal_ascii_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text emitter
// Shared helpers for concurrent checks on the local clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Check that is ignored while reset is asserted.
`define B2D_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that also holds during reset.
`define B2D_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/b2d_pkg.sv]
// ----------------------------------------------------------------------------
// Decimal text emitter package
// Shared types, character codes and place weights.
// ----------------------------------------------------------------------------
package b2d_pkg;

	localparam int VALUE_W    = 16;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int NUM_PLACES = 4;
	localparam int MULT_W     = 17;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_CR   = 8'h0D;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [2:0] pos_t;
	localparam pos_t POS_UNITS = 3'd4;
	localparam pos_t POS_CR    = 3'd5;

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef struct packed {
		digit_t [NUM_PLACES-1:0] digits;
		digit_t                  units;
		pos_t                    start;
	} number_t;

	function automatic logic [MULT_W-1:0] place_weight(input logic [1:0] place);
		logic [MULT_W-1:0] w;
		case (place)
			2'd0:    w = 17'd10000;
			2'd1:    w = 17'd1000;
			2'd2:    w = 17'd100;
			default: w = 17'd10;
		endcase
		return w;
	endfunction

	function automatic logic [MULT_W-1:0] place_multiple(input logic [1:0] place,
			input digit_t k);
		logic [2*MULT_W-1:0] prod;
		prod = {{(2*MULT_W-DIGIT_W){1'b0}}, k} * {{MULT_W{1'b0}}, place_weight(place)};
		return prod[MULT_W-1:0];
	endfunction

endpackage

[hw/rtl/b2d_front.sv]
// ----------------------------------------------------------------------------
// Decimal text emitter, front end
// Accepts a value, extracts one decimal digit per cycle; queues when not full.
// ----------------------------------------------------------------------------
module b2d_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [b2d_pkg::VALUE_W-1:0]  s_tdata,   // value[15:0]
	output logic                         push_valid,
	input  logic                         push_ready,
	output b2d_pkg::number_t             push_data
);
	import b2d_pkg::*;

	typedef enum logic {ST_IDLE, ST_CONVERT} state_t;

	state_t                  state_q;
	logic [1:0]              place_q;
	logic [VALUE_W-1:0]      rest_q;
	digit_t [NUM_PLACES-1:0] digits_q;
	logic                    started_q;
	pos_t                    start_q;

	digit_t                  digit;
	logic [MULT_W-1:0]       rest_wide;
	logic [MULT_W-1:0]       rest_next;
	pos_t                    start_next;
	digit_t [NUM_PLACES-1:0] digits_next;
	logic                    last_place;
	logic                    accept;

	always_comb begin
		rest_wide = {1'b0, rest_q};
		digit = '0;
		for (int k = 1; k < 10; k++) begin
			if (rest_wide >= place_multiple(place_q, DIGIT_W'(k))) begin
				digit = DIGIT_W'(k);
			end
		end
		rest_next = rest_wide - place_multiple(place_q, digit);
		start_next = (started_q || digit != '0) ? start_q : start_q + 3'd1;
		digits_next = digits_q;
		digits_next[place_q] = digit;
	end

	assign last_place = (place_q == 2'(NUM_PLACES - 1));
	assign push_valid = (state_q == ST_CONVERT) && last_place;
	assign s_tready   = (state_q == ST_IDLE) || (push_valid && push_ready);
	assign accept     = s_tvalid && s_tready;

	assign push_data.digits = digits_next;
	assign push_data.units  = rest_next[DIGIT_W-1:0];
	assign push_data.start  = start_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			place_q   <= '0;
			started_q <= 1'b0;
			start_q   <= '0;
		end else begin
			if (accept) begin
				state_q   <= ST_CONVERT;
				place_q   <= '0;
				started_q <= 1'b0;
				start_q   <= '0;
			end else if (push_valid && push_ready) begin
				state_q <= ST_IDLE;
			end else if (state_q == ST_CONVERT && !last_place) begin
				place_q   <= place_q + 2'd1;
				started_q <= started_q || (digit != '0);
				start_q   <= start_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rest_q <= s_tdata;
		end else if (state_q == ST_CONVERT && !last_place) begin
			rest_q      <= rest_next[VALUE_W-1:0];
			digits_q    <= digits_next;
		end
	end

endmodule

[hw/rtl/b2d_queue.sv]
// ----------------------------------------------------------------------------
// Decimal text emitter, digit queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module b2d_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  b2d_pkg::number_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output b2d_pkg::number_t pop_data
);
	import b2d_pkg::*;

	number_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q;
	logic [QUEUE_PTR_W-1:0] rd_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

[hw/rtl/b2d_back.sv]
// ----------------------------------------------------------------------------
// Decimal text emitter, back end
// Turns queued digits to ASCII characters ending in CR, one per cycle if ready.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_defines.svh"

module b2d_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  b2d_pkg::number_t            pop_data,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [b2d_pkg::CHAR_W-1:0]  m_tdata,   // character[7:0]
	output logic                        m_tlast    // last
);
	import b2d_pkg::*;

	number_t             cur_q;
	logic                have_q;
	pos_t                pos_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_last_q;

	logic                load;
	logic                advance;
	logic                finish;
	logic [CHAR_W-1:0]   char_next;
	digit_t              digit_sel;

	assign load      = !out_valid_q || m_tready;
	assign advance   = load && have_q;
	assign finish    = advance && (pos_q == POS_CR);
	assign pop_ready = !have_q || finish;

	always_comb begin
		digit_sel = (pos_q == POS_UNITS) ? cur_q.units : cur_q.digits[pos_q[1:0]];
		char_next = (pos_q == POS_CR) ? ASCII_CR : ASCII_ZERO + {4'b0, digit_sel};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				have_q <= 1'b1;
				pos_q  <= pop_data.start;
			end else if (finish) begin
				have_q <= 1'b0;
			end else if (advance) begin
				pos_q <= pos_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= have_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_q <= pop_data;
		end
		if (advance) begin
			out_char_q <= char_next;
			out_last_q <= (pos_q == POS_CR);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

	`B2D_ASSERT_RST(a_last_is_cr, out_valid_q && out_last_q |-> out_char_q == ASCII_CR, "last character is not CR")
	`B2D_ASSERT_RST(a_digit_range, out_valid_q && !out_last_q |-> out_char_q >= ASCII_ZERO && out_char_q <= ASCII_ZERO + 8'd9, "non-final character is not a digit")
	`B2D_ASSERT_ALWAYS(a_pos_range, have_q |-> pos_q <= POS_CR, "character position out of range")

endmodule

[hw/rtl/binary_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// Decimal text emitter
// Takes a 16-bit unsigned value per input transaction and sends its decimal
// form as ASCII characters, most significant digit first and without leading
// zeros, followed by a carriage return marked with tlast. A front end extracts
// one digit per cycle with a bank of constant compares and a subtract, waiting
// while the queue is full; a two-entry queue decouples it from the back end,
// which sends one character per cycle through a registered output while the
// output is ready. A value yields two to six output transactions; a new value
// is accepted while earlier characters are sent.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [b2d_pkg::VALUE_W-1:0]  s_tdata,   // value[15:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [b2d_pkg::CHAR_W-1:0]   m_tdata,   // character[7:0]
	output logic                         m_tlast    // last
);
	import b2d_pkg::*;

	logic    push_valid;
	logic    push_ready;
	number_t push_data;
	logic    pop_valid;
	logic    pop_ready;
	number_t pop_data;

	b2d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	b2d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	b2d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
